// File: hw/rtl/ca3d_pkg.sv
// Package for the three-dimensional generations automaton.
// Holds the function codes, controller states and the neighbour offset table.
// No dependencies.
`default_nettype none

package ca3d_pkg;

	// item function codes
	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_GEN   = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SIDE     = 3'd0,
		REG_SPAWN    = 3'd1,
		REG_SURVIVAL = 3'd2,
		REG_MAXSTATE = 3'd3,
		REG_MOORE    = 3'd4
	} reg_idx_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_GISSUE,
		ST_GDRAIN,
		ST_GWRITE,
		ST_CRD,
		ST_CWR,
		ST_FIN
	} state_t;

	// one axis step of a neighbour offset
	typedef enum logic [1:0] {
		OFF_ZERO  = 2'd0,
		OFF_PLUS  = 2'd1,
		OFF_MINUS = 2'd2
	} off_t;

	typedef struct packed {
		off_t dx;
		off_t dy;
		off_t dz;
	} nbr_off_t;

	localparam int unsigned MOORE_LAST = 26;
	localparam int unsigned VN_LAST    = 6;
	localparam int unsigned CNT_BITS   = 5;

	// Entry 0 is the cell itself; 1..26 Moore, 1..6 von Neumann.
	function automatic nbr_off_t nbr_off(input logic [CNT_BITS-1:0] idx, input logic moore);
		nbr_off_t o;
		o = '{OFF_ZERO, OFF_ZERO, OFF_ZERO};
		if (!moore) begin
			case (idx)
				5'd1:    o = '{OFF_PLUS,  OFF_ZERO,  OFF_ZERO};
				5'd2:    o = '{OFF_MINUS, OFF_ZERO,  OFF_ZERO};
				5'd3:    o = '{OFF_ZERO,  OFF_PLUS,  OFF_ZERO};
				5'd4:    o = '{OFF_ZERO,  OFF_MINUS, OFF_ZERO};
				5'd5:    o = '{OFF_ZERO,  OFF_ZERO,  OFF_PLUS};
				5'd6:    o = '{OFF_ZERO,  OFF_ZERO,  OFF_MINUS};
				default: o = '{OFF_ZERO,  OFF_ZERO,  OFF_ZERO};
			endcase
		end else begin
			case (idx)
				5'd1:    o = '{OFF_MINUS, OFF_MINUS, OFF_MINUS};
				5'd2:    o = '{OFF_MINUS, OFF_MINUS, OFF_ZERO};
				5'd3:    o = '{OFF_MINUS, OFF_MINUS, OFF_PLUS};
				5'd4:    o = '{OFF_MINUS, OFF_ZERO,  OFF_MINUS};
				5'd5:    o = '{OFF_MINUS, OFF_ZERO,  OFF_ZERO};
				5'd6:    o = '{OFF_MINUS, OFF_ZERO,  OFF_PLUS};
				5'd7:    o = '{OFF_MINUS, OFF_PLUS,  OFF_MINUS};
				5'd8:    o = '{OFF_MINUS, OFF_PLUS,  OFF_ZERO};
				5'd9:    o = '{OFF_MINUS, OFF_PLUS,  OFF_PLUS};
				5'd10:   o = '{OFF_ZERO,  OFF_MINUS, OFF_MINUS};
				5'd11:   o = '{OFF_ZERO,  OFF_MINUS, OFF_ZERO};
				5'd12:   o = '{OFF_ZERO,  OFF_MINUS, OFF_PLUS};
				5'd13:   o = '{OFF_ZERO,  OFF_ZERO,  OFF_MINUS};
				5'd14:   o = '{OFF_ZERO,  OFF_ZERO,  OFF_PLUS};
				5'd15:   o = '{OFF_ZERO,  OFF_PLUS,  OFF_MINUS};
				5'd16:   o = '{OFF_ZERO,  OFF_PLUS,  OFF_ZERO};
				5'd17:   o = '{OFF_ZERO,  OFF_PLUS,  OFF_PLUS};
				5'd18:   o = '{OFF_PLUS,  OFF_MINUS, OFF_MINUS};
				5'd19:   o = '{OFF_PLUS,  OFF_MINUS, OFF_ZERO};
				5'd20:   o = '{OFF_PLUS,  OFF_MINUS, OFF_PLUS};
				5'd21:   o = '{OFF_PLUS,  OFF_ZERO,  OFF_MINUS};
				5'd22:   o = '{OFF_PLUS,  OFF_ZERO,  OFF_ZERO};
				5'd23:   o = '{OFF_PLUS,  OFF_ZERO,  OFF_PLUS};
				5'd24:   o = '{OFF_PLUS,  OFF_PLUS,  OFF_MINUS};
				5'd25:   o = '{OFF_PLUS,  OFF_PLUS,  OFF_ZERO};
				5'd26:   o = '{OFF_PLUS,  OFF_PLUS,  OFF_PLUS};
				default: o = '{OFF_ZERO,  OFF_ZERO,  OFF_ZERO};
			endcase
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cellular_automaton_3d_generation.sv
// Cell write and read: one item at a time; no new item is taken until the result word is out.
// Generation: each active cell reads its center and N neighbours (N = 26 Moore, 6 von Neumann)
// over the single grid read port, and then every cell is copied back from the staging memory.
// After reset a clearing pass over all 2^(3*clog2(MAX_SIDE)) grid entries (32768 by default)
// zeroes the grid; no input word is taken until it ends.
// Depends on ca3d_pkg.
`default_nettype none

module cellular_automaton_3d_generation #(
	parameter int unsigned MAX_SIDE   = 32,
	parameter int unsigned STATE_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [26:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [4:0]  pos_x,
	input  wire logic [4:0]  pos_y,
	input  wire logic [4:0]  pos_z,
	input  wire logic [7:0]  cell_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_value,
	output logic             done_res
);
	import ca3d_pkg::*;

	localparam int unsigned CW = $clog2(MAX_SIDE);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned AW = 3 * CW;
	localparam int unsigned DEPTH = 1 << AW;

	// configuration registers
	logic [5:0]  side_length_q;
	logic [26:0] spawn_mask_q;
	logic [26:0] survival_mask_q;
	logic [7:0]  max_state_q;
	logic        moore_mode_q;

	// grid memories
	logic [STATE_BITS-1:0] cell_mem [DEPTH];
	logic [STATE_BITS-1:0] next_mem [DEPTH];
	logic [STATE_BITS-1:0] cell_rd_q;
	logic [STATE_BITS-1:0] next_rd_q;

	// control
	state_t state_q, state_d;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       x_q, y_q, z_q;
	logic [CNT_BITS-1:0] idx_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [STATE_BITS-1:0] center_q;
	logic                vld_s1, ctr_s1;
	logic                inside_q;
	logic [7:0]          res_rv_q;
	logic                res_done_q;
	logic                out_valid_q;
	logic [7:0]          read_value_q;
	logic                done_q;

	// combinational
	logic [7:0]    side_ext, side_cl;
	logic [SW-1:0] side;
	logic [CW-1:0] side_m1;
	logic          accept, inside_in, out_free, last_idx, last_cell;
	logic [CW-1:0] px, py, pz;
	nbr_off_t      off;
	logic [AW-1:0] nbr_addr, cur_addr, in_addr;
	logic [15:0]   val_ext;
	logic [STATE_BITS-1:0] new_state;

	// clamp the active side to 2..MAX_SIDE
	always_comb begin
		side_ext = {2'b0, side_length_q};
		if (side_ext < 8'd2)
			side_cl = 8'd2;
		else if (side_ext > 8'(MAX_SIDE))
			side_cl = 8'(MAX_SIDE);
		else
			side_cl = side_ext;
		side    = side_cl[SW-1:0];
		side_m1 = CW'(side - SW'(1));
	end

	function automatic logic [CW-1:0] wrapc(input logic [CW-1:0] c, input off_t d,
			input logic [CW-1:0] m1);
		logic [CW-1:0] r;
		r = c;
		case (d)
			OFF_PLUS:  r = (c == m1) ? '0 : c + CW'(1);
			OFF_MINUS: r = (c == '0) ? m1 : c - CW'(1);
			default:   r = c;
		endcase
		return r;
	endfunction

	// addressing
	always_comb begin
		off       = nbr_off(idx_q, moore_mode_q);
		nbr_addr  = {wrapc(z_q, off.dz, side_m1), wrapc(y_q, off.dy, side_m1),
			wrapc(x_q, off.dx, side_m1)};
		cur_addr  = {z_q, y_q, x_q};
		px        = CW'(pos_x);
		py        = CW'(pos_y);
		pz        = CW'(pos_z);
		in_addr   = {pz, py, px};
		inside_in = ({3'b0, pos_x} < side_cl) && ({3'b0, pos_y} < side_cl)
			&& ({3'b0, pos_z} < side_cl);
		val_ext   = {8'b0, cell_value};
		last_idx  = moore_mode_q ? (idx_q == CNT_BITS'(MOORE_LAST))
			: (idx_q == CNT_BITS'(VN_LAST));
		last_cell = (x_q == side_m1) && (y_q == side_m1) && (z_q == side_m1);
	end

	// generation rule for one cell
	always_comb begin
		logic [16:0] inc;
		inc = 17'(center_q) + 17'd1;
		if (center_q == '0)
			new_state = spawn_mask_q[cnt_q] ? STATE_BITS'(1) : '0;
		else if (center_q != STATE_BITS'(1) || !survival_mask_q[cnt_q])
			new_state = (inc >= 17'(max_state_q)) ? '0 : inc[STATE_BITS-1:0];
		else
			new_state = center_q;
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign done_res   = done_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FN_READ: state_d = ST_RDWAIT;
						FN_GEN:  state_d = ST_GISSUE;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_RDWAIT: state_d = ST_FIN;
			ST_GISSUE: if (last_idx) state_d = ST_GDRAIN;
			ST_GDRAIN: state_d = ST_GWRITE;
			ST_GWRITE: state_d = last_cell ? ST_CRD : ST_GISSUE;
			ST_CRD:    state_d = ST_CWR;
			ST_CWR:    state_d = last_cell ? ST_FIN : ST_CRD;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_length_q   <= 6'd32;
			spawn_mask_q    <= '0;
			survival_mask_q <= '0;
			max_state_q     <= 8'd2;
			moore_mode_q    <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SIDE:     side_length_q   <= cfg_data[5:0];
				REG_SPAWN:    spawn_mask_q    <= cfg_data;
				REG_SURVIVAL: survival_mask_q <= cfg_data;
				REG_MAXSTATE: max_state_q     <= cfg_data[7:0];
				REG_MOORE:    moore_mode_q    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// grid memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			cell_mem[clr_q] <= '0;
		else if (accept && func_t'(func) == FN_WRITE && inside_in)
			cell_mem[in_addr] <= val_ext[STATE_BITS-1:0];
		else if (state_q == ST_CWR)
			cell_mem[cur_addr] <= next_rd_q;
		cell_rd_q <= cell_mem[(state_q == ST_IDLE) ? in_addr : nbr_addr];
	end

	// staging memory for the new generation
	always_ff @(posedge clk) begin
		if (state_q == ST_GWRITE)
			next_mem[cur_addr] <= new_state;
		next_rd_q <= next_mem[cur_addr];
	end

	// sequencer counters and neighbour accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			z_q      <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			center_q <= '0;
			vld_s1   <= 1'b0;
			ctr_s1   <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + AW'(1);
			vld_s1 <= (state_q == ST_GISSUE);
			ctr_s1 <= (idx_q == '0);
			if (state_q == ST_GISSUE)
				idx_q <= idx_q + CNT_BITS'(1);
			// count neighbours in state one, keep the center
			if (vld_s1) begin
				if (ctr_s1)
					center_q <= cell_rd_q;
				else if (cell_rd_q == STATE_BITS'(1))
					cnt_q <= cnt_q + CNT_BITS'(1);
			end
			if (state_q == ST_IDLE) begin
				x_q   <= '0;
				y_q   <= '0;
				z_q   <= '0;
				idx_q <= '0;
				cnt_q <= '0;
			end
			// advance the cell position after each write
			if (state_q == ST_GWRITE || state_q == ST_CWR) begin
				idx_q <= '0;
				cnt_q <= '0;
				if (x_q != side_m1) begin
					x_q <= x_q + CW'(1);
				end else begin
					x_q <= '0;
					if (y_q != side_m1) begin
						y_q <= y_q + CW'(1);
					end else begin
						y_q <= '0;
						z_q <= (z_q != side_m1) ? z_q + CW'(1) : '0;
					end
				end
			end
		end
	end

	// hold the pending result
	always_ff @(posedge clk) begin
		logic [15:0] rd_ext;
		rd_ext = 16'(cell_rd_q);
		if (accept) begin
			inside_q   <= inside_in;
			res_rv_q   <= '0;
			res_done_q <= (func_t'(func) != FN_NONE);
		end
		if (state_q == ST_RDWAIT)
			res_rv_q <= inside_q ? rd_ext[7:0] : 8'd0;
	end

	// output register: drop the word when taken, load when finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			read_value_q <= res_rv_q;
			done_q       <= res_done_q;
		end
	end

endmodule

`default_nettype wire
